>>> hw/rtl/svpwm_pkg.sv
package svpwm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TICKS_PER_US = 100;

    localparam int VOLT_W = 32;
    localparam int FSV_W  = 31;
    localparam int PER_W  = 16;
    localparam int CNT_W  = 23;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 1;

    localparam int TB_W   = $clog2(TICKS_PER_US + 1);
    localparam int TICK_W = (PER_W + TB_W > CNT_W) ? PER_W + TB_W : CNT_W + 1;
    localparam int STEP_W = $clog2(FRAC_BITS);

    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [TICK_W-1:0] DUTY_OFS  = TICK_W'(3);
    localparam logic [TICK_W-1:0] PER_OFS   = TICK_W'(2);

    localparam logic [FSV_W-1:0] FSV_RESET = FSV_W'(786432);
    localparam logic [PER_W-1:0] PER_RESET = PER_W'(1000);

    localparam logic [IDX_W-1:0] REG_FULL_SCALE = 1'b0;
    localparam logic [IDX_W-1:0] REG_PERIOD     = 1'b1;

    localparam logic REQ_VOLTAGE = 1'b0;

    // bit0 = bridge_a, bit1 = bridge_b
    localparam logic [1:0] PIN_OFF = 2'b00;
    localparam logic [1:0] PIN_POS = 2'b01;
    localparam logic [1:0] PIN_NEG = 2'b10;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_PUSH
    } top_state_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_CHECK,
        D_DIV,
        D_MUL,
        D_SCALE
    } duty_state_t;

    typedef struct packed {
        logic              start;
        logic [VOLT_W-1:0] mag;
    } duty_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } duty_rsp_t;

    function automatic logic [CNT_W-1:0] to_count(input logic [PER_W-1:0] units,
                                                  input logic [TICK_W-1:0] minus);
        logic [TICK_W-1:0] t;
        logic [TICK_W-1:0] d;
        t = TICK_W'(units) * TICK_W'(TICKS_PER_US);
        d = t - minus;
        if (units == '0 || t <= minus) begin
            return '0;
        end else if (d > TICK_W'(COUNT_MAX)) begin
            return COUNT_MAX;
        end else begin
            return CNT_W'(d);
        end
    endfunction

endpackage

>>> hw/rtl/signed_voltage_to_pwm_hbridge_drive.sv
// H-bridge PWM drive. Each input transaction either sets the signed fixed-point
// voltage command (tuser = 0) or starts/stops the drive (tuser = 1); every
// transaction returns exactly one result with the timer duty and period counts,
// the two bridge pins, timer enable, a direction-flip flag and the run state.
// Stop and voltage updates while stopped bypass the duty unit. A duty recompute
// returns a zero duty for a zero voltage and a duty of the whole period when |v|
// reaches full scale; otherwise the restoring divider forms |v| / full_scale one
// quotient bit per cycle, followed by one 16x16 multiply by the period. A stalled
// output delays the loading of the next result. The block takes a new
// transaction while a finished result still waits at the output register.
// Configuration writes are ignored while the drive runs.
module signed_voltage_to_pwm_hbridge_drive (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // voltage_cmd[31:0], run_request[32]
    input  logic                        s_tuser,   // req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // duty_count[22:0], period_count[45:23], bridge_a[46], bridge_b[47],
    // timer_on[48], direction_flip[49], running_now[50]
    output logic [55:0]                 m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [svpwm_pkg::IDX_W-1:0] cfg_index,
    input  logic [svpwm_pkg::CFG_W-1:0] cfg_data
);
    import svpwm_pkg::*;

    top_state_t        state_reg, state_next;
    logic [VOLT_W-1:0] volt_reg, volt_next;
    logic              run_reg, run_next;
    logic [1:0]        pin_reg, pin_next;
    logic [CNT_W-1:0]  drv_duty_reg, drv_duty_next;
    logic [CNT_W-1:0]  drv_period_reg, drv_period_next;
    logic              timer_reg, timer_next;
    logic              flip_reg, flip_next;
    logic [FSV_W-1:0]  fsv_reg, fsv_next;
    logic [PER_W-1:0]  per_reg, per_next;
    logic              m_valid_reg, m_valid_next;
    logic [55:0]       m_data_reg, m_data_next;

    logic              accept;
    logic              load_out;
    logic              needs_duty;
    logic [VOLT_W-1:0] vcmd;
    logic [VOLT_W-1:0] mag_src;
    duty_req_t         dreq;
    duty_rsp_t         drsp;

    assign vcmd    = s_tdata[VOLT_W-1:0];
    assign accept  = s_tvalid && s_tready;
    assign mag_src = (s_tuser == REQ_VOLTAGE) ? vcmd : volt_reg;
    assign needs_duty = (s_tuser == REQ_VOLTAGE) ? run_reg : s_tdata[32];

    svpwm_duty u_duty (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (dreq),
        .full_scale (fsv_reg),
        .period     (per_reg),
        .rsp        (drsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (accept) state_next = needs_duty ? T_CALC : T_PUSH;
            end
            T_CALC: begin
                if (drsp.done) state_next = T_PUSH;
            end
            T_PUSH: begin
                if (!m_valid_reg || m_tready) state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == T_IDLE);
        load_out   = (state_reg == T_PUSH) && (!m_valid_reg || m_tready);
        dreq.start = accept && needs_duty;
        dreq.mag   = mag_src[VOLT_W-1] ? (~mag_src + 1'b1) : mag_src;
    end

    always_comb begin
        volt_next       = volt_reg;
        run_next        = run_reg;
        pin_next        = pin_reg;
        drv_duty_next   = drv_duty_reg;
        drv_period_next = drv_period_reg;
        timer_next      = timer_reg;
        flip_next       = flip_reg;
        fsv_next        = fsv_reg;
        per_next        = per_reg;

        if (accept) begin
            flip_next = 1'b0;
            if (s_tuser == REQ_VOLTAGE) begin
                volt_next = vcmd;
                if (run_reg && (vcmd[VOLT_W-1] != volt_reg[VOLT_W-1])) begin
                    flip_next = 1'b1;
                    pin_next  = vcmd[VOLT_W-1] ? PIN_NEG : PIN_POS;
                end
            end else if (s_tdata[32]) begin
                run_next        = 1'b1;
                pin_next        = volt_reg[VOLT_W-1] ? PIN_NEG : PIN_POS;
                drv_period_next = to_count(per_reg, PER_OFS);
                timer_next      = 1'b1;
            end else begin
                run_next        = 1'b0;
                pin_next        = PIN_OFF;
                drv_duty_next   = '0;
                drv_period_next = '0;
                timer_next      = 1'b0;
            end
        end

        if (state_reg == T_CALC && drsp.done) drv_duty_next = drsp.count;

        if (cfg_wr_en && !run_reg) begin
            case (cfg_index)
                REG_FULL_SCALE: fsv_next = cfg_data[FSV_W-1:0];
                REG_PERIOD:     per_next = cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {5'b0, run_reg, flip_reg, timer_reg, pin_reg[1], pin_reg[0],
                            drv_period_reg, drv_duty_reg};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            volt_reg       <= '0;
            run_reg        <= 1'b0;
            pin_reg        <= PIN_OFF;
            drv_duty_reg   <= '0;
            drv_period_reg <= '0;
            timer_reg      <= 1'b0;
            flip_reg       <= 1'b0;
            fsv_reg        <= FSV_RESET;
            per_reg        <= PER_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            volt_reg       <= volt_next;
            run_reg        <= run_next;
            pin_reg        <= pin_next;
            drv_duty_reg   <= drv_duty_next;
            drv_period_reg <= drv_period_next;
            timer_reg      <= timer_next;
            flip_reg       <= flip_next;
            fsv_reg        <= fsv_next;
            per_reg        <= per_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

>>> hw/rtl/svpwm_duty.sv
module svpwm_duty (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  svpwm_pkg::duty_req_t        req,
    input  logic [svpwm_pkg::FSV_W-1:0] full_scale,
    input  logic [svpwm_pkg::PER_W-1:0] period,
    output svpwm_pkg::duty_rsp_t        rsp
);
    import svpwm_pkg::*;

    duty_state_t                 state_reg, state_next;
    logic [VOLT_W-1:0]           rem_reg, rem_next;
    logic [FRAC_BITS-1:0]        quo_reg, quo_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [PER_W-1:0]            dus_reg, dus_next;
    logic [FRAC_BITS+PER_W-1:0]  prod;

    // shared subtract/compare
    logic [VOLT_W-1:0] opnd;
    logic [VOLT_W:0]   diff;
    logic              ge;

    assign opnd = (state_reg == D_DIV) ? {rem_reg[VOLT_W-2:0], 1'b0} : rem_reg;
    assign diff = {1'b0, opnd} - {2'b00, full_scale};
    assign ge   = !diff[VOLT_W];
    assign prod = (FRAC_BITS+PER_W)'(quo_reg) * (FRAC_BITS+PER_W)'(period);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) state_next = D_CHECK;
            end
            D_CHECK: begin
                if (rem_reg == '0) state_next = D_IDLE;
                else if (ge)       state_next = D_SCALE;
                else               state_next = D_DIV;
            end
            D_DIV: begin
                if (step_reg == STEP_W'(FRAC_BITS - 1)) state_next = D_MUL;
            end
            D_MUL:   state_next = D_SCALE;
            D_SCALE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        dus_next  = dus_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    rem_next  = req.mag;
                    step_next = '0;
                end
            end
            D_CHECK: begin
                dus_next = period;
            end
            D_DIV: begin
                rem_next  = ge ? diff[VOLT_W-1:0] : opnd;
                quo_next  = {quo_reg[FRAC_BITS-2:0], ge};
                step_next = step_reg + 1'b1;
            end
            D_MUL: begin
                dus_next = prod[FRAC_BITS+PER_W-1:FRAC_BITS];
            end
            default: ;
        endcase
    end

    always_comb begin
        rsp.done  = (state_reg == D_SCALE) || (state_reg == D_CHECK && rem_reg == '0);
        rsp.count = (state_reg == D_SCALE) ? to_count(dus_reg, DUTY_OFS) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        dus_reg  <= dus_next;
    end

endmodule

>>> hw/rtl/svpwm_chk.sv
module svpwm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // both bridge legs never driven at once
    a_no_shoot_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[46] && m_tdata[47]))
        else $error("bridge pins both high");

    // stopped drive shows a fully cleared bridge
    a_stop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[50]) |->
            (m_tdata[22:0] == 23'd0 && m_tdata[45:23] == 23'd0 &&
             m_tdata[47:46] == 2'b00 && !m_tdata[48] && !m_tdata[49]))
        else $error("stopped result not cleared");

    // duty never exceeds period while running
    a_duty_le_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[50]) |-> (m_tdata[22:0] <= m_tdata[45:23]))
        else $error("duty above period");

    // timer enable tracks run state
    a_timer_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48] == m_tdata[50]))
        else $error("timer enable differs from run state");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");

endmodule

bind signed_voltage_to_pwm_hbridge_drive svpwm_chk u_svpwm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import svpwm_pkg::*;

    localparam logic REQ_RUN      = 1'b1;
    localparam int   DRAIN_CYCLES = 60;
    localparam int   STALL_LIMIT  = 4000;
    localparam int   PHASE_ITEMS  = 128;

    // packed so that the lowest member lines up with m_tdata[0]
    typedef struct packed {
        logic             running;
        logic             flip;
        logic             timer_on;
        logic             bridge_b;
        logic             bridge_a;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] duty;
    } drive_result_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [55:0]      m_tdata;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic idle_en      = 1'b1;
    int   errors       = 0;
    int   quiet_cycles = 0;

    // predicted drive state
    logic [FSV_W-1:0] fsv_reg;
    logic [PER_W-1:0] per_reg;
    logic [31:0]      cmd_volt;
    logic             drive_on;
    logic [1:0]       pins;
    logic [CNT_W-1:0] duty_hold;
    logic [CNT_W-1:0] period_hold;
    logic             timer_hold;

    drive_result_t pending_results[$];

    signed_voltage_to_pwm_hbridge_drive dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [CNT_W-1:0] us_to_ticks(input longint unsigned us,
                                                     input longint unsigned ofs);
        longint unsigned t;
        t = us * TICKS_PER_US;
        if (us == 0 || t <= ofs) begin
            return '0;
        end
        t = t - ofs;
        return (t > COUNT_MAX) ? COUNT_MAX : CNT_W'(t);
    endfunction

    function automatic logic [CNT_W-1:0] duty_ticks();
        logic [31:0]     neg;
        longint unsigned mag;
        longint unsigned ratio;
        longint unsigned us;
        neg = -cmd_volt;
        mag = 64'(cmd_volt[31] ? neg : cmd_volt);
        if (mag == 0) begin
            return '0;
        end
        if (fsv_reg == 0) begin
            us = 64'(per_reg);
        end else begin
            ratio = (mag << FRAC_BITS) / fsv_reg;
            if (ratio >= (64'd1 << FRAC_BITS)) begin
                us = 64'(per_reg);
            end else begin
                us = (ratio * per_reg) >> FRAC_BITS;
            end
        end
        return us_to_ticks(us, 3);
    endfunction

    function automatic drive_result_t drive_step(input logic req, input logic [31:0] v,
                                                 input logic run_req);
        drive_result_t r;
        logic          flip;
        flip = 1'b0;
        if (req == REQ_VOLTAGE) begin
            if (drive_on) begin
                if (cmd_volt[31] != v[31]) begin
                    flip = 1'b1;
                    pins = v[31] ? PIN_NEG : PIN_POS;
                end
                cmd_volt  = v;
                duty_hold = duty_ticks();
            end else begin
                cmd_volt = v;
            end
        end else if (run_req) begin
            drive_on    = 1'b1;
            pins        = cmd_volt[31] ? PIN_NEG : PIN_POS;
            period_hold = us_to_ticks(64'(per_reg), 2);
            duty_hold   = duty_ticks();
            timer_hold  = 1'b1;
        end else begin
            drive_on    = 1'b0;
            pins        = PIN_OFF;
            duty_hold   = '0;
            period_hold = '0;
            timer_hold  = 1'b0;
        end
        r.duty     = duty_hold;
        r.period   = period_hold;
        r.bridge_a = pins[0];
        r.bridge_b = pins[1];
        r.timer_on = timer_hold;
        r.flip     = flip;
        r.running  = drive_on;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input drive_result_t got);
        drive_result_t want;
        if (pending_results.size() == 0) begin
            $error("result with nothing expected: %h", got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        check_field("duty_count", 32'(want.duty), 32'(got.duty));
        check_field("period_count", 32'(want.period), 32'(got.period));
        check_field("bridge_a", 32'(want.bridge_a), 32'(got.bridge_a));
        check_field("bridge_b", 32'(want.bridge_b), 32'(got.bridge_b));
        check_field("timer_on", 32'(want.timer_on), 32'(got.timer_on));
        check_field("direction_flip", 32'(want.flip), 32'(got.flip));
        check_field("running_now", 32'(want.running), 32'(got.running));
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result(m_tdata[$bits(drive_result_t)-1:0]);
        end
        m_tready <= !(idle_en && $urandom_range(99) < 6);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_item(input logic req, input logic [31:0] v, input logic run_req);
        if (idle_en && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, run_req, v};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(drive_step(req, v, run_req));
    endtask

    task automatic set_voltage(input logic [31:0] v);
        send_item(REQ_VOLTAGE, v, 1'($urandom));
    endtask

    task automatic set_run(input logic run_req);
        send_item(REQ_RUN, $urandom, run_req);
    endtask

    // lower valid, wait out every result, then run out the DRAIN_CYCLES drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (!drive_on) begin
            if (idx == REG_FULL_SCALE) begin
                fsv_reg = value;
            end else begin
                per_reg = value[PER_W-1:0];
            end
        end
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_voltage();
        longint unsigned lim;
        logic [31:0]     mag;
        int              sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0001;
                default: return 32'hFFFF_FFFF;
            endcase
        end else if (sel < 4) begin
            return $urandom;
        end
        lim = (fsv_reg == 0) ? 1000 : fsv_reg + fsv_reg / 4;
        if (lim > 32'h7FFF_FFFF) begin
            lim = 32'h7FFF_FFFF;
        end
        mag = $urandom_range(0, 32'(lim));
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic test_stopped_then_start();
        set_voltage(32'h0006_0000);
        set_voltage(32'hFFFD_0000);
        set_run(1'b1);
        set_run(1'b1);
    endtask

    task automatic test_direction_changes();
        set_voltage(32'h0006_0000);
        set_voltage(32'h0000_0000);
        set_voltage(32'hFFFF_FFFF);
        set_voltage(32'h8000_0000);
        set_voltage(32'h7FFF_FFFF);
        set_voltage(32'h000C_0000);
        set_run(1'b0);
        set_run(1'b0);
    endtask

    task automatic test_config_extremes();
        settle();
        cfg_write(REG_FULL_SCALE, '0);
        cfg_write(REG_PERIOD, 31'h0000_FFFF);
        set_run(1'b1);
        set_voltage(32'h0000_0001);
        set_voltage(32'h0000_0000);
        set_run(1'b0);
        settle();
        cfg_write(REG_FULL_SCALE, 31'd1);
        cfg_write(REG_PERIOD, 31'd1);
        set_run(1'b1);
        set_voltage(32'hFFFF_FFFF);
        set_run(1'b0);
        settle();
        cfg_write(REG_PERIOD, '0);
        set_run(1'b1);
        set_voltage(32'h0000_0005);
        set_run(1'b0);
        settle();
        cfg_write(REG_FULL_SCALE, 31'h7FFF_FFFF);
        cfg_write(REG_PERIOD, 31'h7FFF_03E8);
        set_run(1'b1);
        set_voltage(32'h7FFF_FFFF);
        set_voltage(32'hC000_0000);
    endtask

    // settings are locked while the drive runs
    task automatic test_locked_config();
        settle();
        cfg_write(REG_FULL_SCALE, 31'd1);
        cfg_write(REG_PERIOD, 31'd7);
        set_voltage(32'h2000_0000);
        set_run(1'b1);
        set_run(1'b0);
        settle();
        cfg_write(REG_FULL_SCALE, FSV_RESET);
        cfg_write(REG_PERIOD, CFG_W'(PER_RESET));
    endtask

    task automatic random_setup();
        logic [CFG_W-1:0] fs;
        logic [CFG_W-1:0] pd;
        settle();
        if ($urandom_range(3) != 0) begin
            set_run(1'b0);
            settle();
        end
        case ($urandom_range(5))
            0:       fs = '0;
            1:       fs = 31'd1;
            2:       fs = 31'h7FFF_FFFF;
            3:       fs = FSV_RESET;
            4:       fs = CFG_W'($urandom_range(1, 1 << 20));
            default: fs = CFG_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       pd = '0;
            1:       pd = 31'd1;
            2:       pd = 31'h0000_FFFF;
            3:       pd = CFG_W'(PER_RESET);
            4:       pd = CFG_W'($urandom_range(1, 65535));
            default: pd = CFG_W'($urandom);
        endcase
        cfg_write(REG_FULL_SCALE, fs);
        cfg_write(REG_PERIOD, pd);
    endtask

    task automatic test_random();
        int pick;
        for (int phase = 0; phase < 8; phase++) begin
            random_setup();
            idle_en = (phase != 3);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    set_run(1'b1);
                end else if (pick < 18) begin
                    set_run(1'b0);
                end else begin
                    set_voltage(pick_voltage());
                end
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        fsv_reg     = FSV_RESET;
        per_reg     = PER_RESET;
        cmd_volt    = '0;
        drive_on    = 1'b0;
        pins        = PIN_OFF;
        duty_hold   = '0;
        period_hold = '0;
        timer_hold  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_stopped_then_start();
        test_direction_changes();
        test_config_extremes();
        test_locked_config();
        test_random();
        settle();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
